// ===== design/cdlp_pkg.sv =====
`default_nettype none
package cdlp_pkg;

	localparam int LINE_WIDTH  = 320;
	localparam int FRAME_ROWS  = 240;
	localparam int PROBE_DEPTH = 32;
	localparam int QUEUE_DEPTH = 4;

	localparam int COL_W   = $clog2(LINE_WIDTH);
	localparam int ROW_W   = $clog2(FRAME_ROWS);
	localparam int POS_W   = 15;
	localparam int PPTR_W  = $clog2(PROBE_DEPTH);
	localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int CIDX_W  = 2;
	localparam int CDATA_W = 9;

	localparam logic [CIDX_W-1:0] CFG_CHANNEL   = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_PROBE_COL = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_PROBE_ROW = 2'd2;

	localparam logic [1:0] CHAN_LUMA  = 2'd0;
	localparam logic [1:0] CHAN_RED   = 2'd1;
	localparam logic [1:0] CHAN_GREEN = 2'd2;
	localparam logic [1:0] CHAN_BLUE  = 2'd3;

	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	localparam logic [1:0]       CHAN_RESET      = CHAN_LUMA;
	localparam logic [COL_W-1:0] PROBE_COL_RESET = COL_W'(160);
	localparam logic [ROW_W-1:0] PROBE_ROW_RESET = ROW_W'(120);

	typedef struct packed {
		logic        kind;
		logic [31:0] camera_word;
	} in_item_t;

	typedef struct packed {
		logic        result_kind;
		logic [15:0] grey_pixel;
		logic [14:0] pixel_index;
		logic        frame_last;
		logic [4:0]  probe_value;
		logic        probe_ok;
	} out_item_t;

	// classified transaction passed from the front to the back
	typedef struct packed {
		logic             is_read;
		logic [4:0]       red;
		logic [4:0]       green;
		logic [4:0]       blue;
		logic [POS_W-1:0] pixel_index;
		logic             frame_last;
		logic             probe_hit;
	} q_item_t;

	function automatic logic [4:0] luma(input logic [4:0] r, input logic [4:0] g,
		input logic [4:0] b);
		logic [12:0] s;
		s = 13'd77 * 13'(r) + 13'd151 * 13'(g) + 13'd28 * 13'(b);
		return s[12:8];
	endfunction

	function automatic logic [PPTR_W-1:0] probe_wrap(input logic [PPTR_W-1:0] p);
		return (p == PPTR_W'(PROBE_DEPTH - 1)) ? '0 : p + PPTR_W'(1);
	endfunction

endpackage
`default_nettype wire

// ===== design/cdlp_front.sv =====
`default_nettype none
module cdlp_front import cdlp_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire in_item_t         in_data,
	input  wire logic [COL_W-1:0] probe_column,
	input  wire logic [ROW_W-1:0] probe_row,
	output logic                  push_valid,
	input  wire logic             push_ready,
	output q_item_t               push_data
);

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [POS_W-1:0] pos_q;
	logic [COL_W:0]   col_sum;
	logic [ROW_W:0]   row_sum;
	logic [ROW_W:0]   row_sum2;
	logic             col_wrap;
	logic             row_wrap;
	logic             accept;
	logic             is_read;
	logic             keep;

	assign is_read  = (in_data.kind == KIND_READ);
	assign keep     = is_read || !row_q[0];
	assign in_ready = push_ready;
	assign accept   = in_valid && in_ready;

	assign push_valid = in_valid && keep;

	assign col_sum  = {1'b0, col_q} + (COL_W+1)'(2);
	assign row_sum  = {1'b0, row_q} + (ROW_W+1)'(1);
	assign row_sum2 = {1'b0, row_q} + (ROW_W+1)'(2);
	assign col_wrap = (col_sum >= (COL_W+1)'(LINE_WIDTH));
	assign row_wrap = (row_sum >= (ROW_W+1)'(FRAME_ROWS));

	always_comb begin
		push_data             = '0;
		push_data.is_read     = is_read;
		push_data.red         = in_data.camera_word[15:11];
		push_data.green       = in_data.camera_word[10:6];
		push_data.blue        = in_data.camera_word[4:0];
		push_data.pixel_index = pos_q;
		push_data.frame_last  = col_wrap && (row_sum2 >= (ROW_W+1)'(FRAME_ROWS));
		push_data.probe_hit   = (col_q == probe_column) && (row_q == probe_row);
	end

	// advance the raster on every camera word, kept or dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			pos_q <= '0;
		end else if (accept && !is_read) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_sum[ROW_W-1:0];
			end else begin
				col_q <= col_sum[COL_W-1:0];
			end
			if (col_wrap && row_wrap) begin
				pos_q <= '0;
			end else if (!row_q[0]) begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/cdlp_queue.sv =====
`default_nettype none
module cdlp_queue import cdlp_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push_valid,
	output logic         push_ready,
	input  wire q_item_t push_data,
	output logic         pop_valid,
	input  wire logic    pop_ready,
	output q_item_t      pop_data
);

	q_item_t           slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	logic              pop;

	assign push_ready = (cnt_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = slot_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/cdlp_back.sv =====
`default_nettype none
module cdlp_back import cdlp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [1:0] channel_select,
	input  wire logic       pop_valid,
	output logic            pop_ready,
	input  wire q_item_t    pop_data,
	output logic            out_valid,
	input  wire logic       out_ready,
	output out_item_t       out_data
);

	logic [4:0]        probe_store [PROBE_DEPTH];
	logic [PPTR_W-1:0] head_q;
	logic [PPTR_W-1:0] tail_q;
	logic              out_valid_q;
	out_item_t         out_q;
	logic              take;
	logic [4:0]        v;
	logic              fifo_empty;
	logic              fifo_full;
	logic              do_push;
	logic              do_pop;
	out_item_t         res;

	assign pop_ready = !out_valid_q || out_ready;
	assign take      = pop_valid && pop_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		case (channel_select)
			CHAN_RED:   v = pop_data.red;
			CHAN_GREEN: v = pop_data.green;
			CHAN_BLUE:  v = pop_data.blue;
			default:    v = luma(pop_data.red, pop_data.green, pop_data.blue);
		endcase
	end

	// one slot stays free so that full and empty differ
	assign fifo_empty = (head_q == tail_q);
	assign fifo_full  = (probe_wrap(tail_q) == head_q);
	assign do_push    = take && !pop_data.is_read && pop_data.probe_hit && !fifo_full;
	assign do_pop     = take && pop_data.is_read && !fifo_empty;

	always_comb begin
		res = '0;
		if (pop_data.is_read) begin
			res.result_kind = KIND_READ;
			res.probe_ok    = !fifo_empty;
			res.probe_value = fifo_empty ? 5'd0 : probe_store[head_q];
		end else begin
			res.result_kind = KIND_PIXEL;
			res.grey_pixel  = {v, v, 1'b0, v};
			res.pixel_index = pop_data.pixel_index;
			res.frame_last  = pop_data.frame_last;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			probe_store[tail_q] <= v;
		end
		if (take) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_push) begin
				tail_q <= probe_wrap(tail_q);
			end
			if (do_pop) begin
				head_q <= probe_wrap(head_q);
			end
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/camera_decimate_luma_probe.sv =====
// Path: an accepted item is stored in the queue, then in the back's output register.
// Throughput: one item per cycle; the front takes a transaction each cycle while the
// four-entry queue has room, and the back retires one each cycle the output is free.
// Odd-row camera words advance the raster and give no result.
// Reset (arst_n low, asynchronous): raster, frame index, probe FIFO pointers, queue
// and output cleared; channel_select 0, probe column 160, probe row 120.
`default_nettype none
module camera_decimate_luma_probe import cdlp_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire in_item_t           in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output out_item_t               out_data,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [CIDX_W-1:0]  cfg_index,
	input  wire logic [CDATA_W-1:0] cfg_data
);

	logic [1:0]       chan_q;
	logic [COL_W-1:0] probe_col_q;
	logic [ROW_W-1:0] probe_row_q;
	logic             f_push_valid;
	logic             f_push_ready;
	q_item_t          f_push_data;
	logic             b_pop_valid;
	logic             b_pop_ready;
	q_item_t          b_pop_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q      <= CHAN_RESET;
			probe_col_q <= PROBE_COL_RESET;
			probe_row_q <= PROBE_ROW_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CHANNEL:   chan_q      <= cfg_data[1:0];
				CFG_PROBE_COL: probe_col_q <= cfg_data[COL_W-1:0];
				CFG_PROBE_ROW: probe_row_q <= cfg_data[ROW_W-1:0];
				default:       ;
			endcase
		end
	end

	cdlp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_data      (in_data),
		.probe_column (probe_col_q),
		.probe_row    (probe_row_q),
		.push_valid   (f_push_valid),
		.push_ready   (f_push_ready),
		.push_data    (f_push_data)
	);

	cdlp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_push_valid),
		.push_ready (f_push_ready),
		.push_data  (f_push_data),
		.pop_valid  (b_pop_valid),
		.pop_ready  (b_pop_ready),
		.pop_data   (b_pop_data)
	);

	cdlp_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.channel_select (chan_q),
		.pop_valid      (b_pop_valid),
		.pop_ready      (b_pop_ready),
		.pop_data       (b_pop_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_data       (out_data)
	);

endmodule
`default_nettype wire
